### rtl/pov_pkg.sv
// shared types, constants and the cordic arctangent table of the hat mapper
package pov_pkg;

	localparam int HAT_W = 16;
	localparam int CFG_W = 17;
	localparam int CFG_IDX_W = 2;
	localparam int PHASE_W = 32;
	localparam int CORDIC_STEPS = 28;
	localparam int REM_W = 14;

	localparam logic [HAT_W-1:0] HAT_CENTERED = 16'hFFFF;
	localparam logic [HAT_W-1:0] FULL_TURN = 16'd36000;
	localparam logic [HAT_W-1:0] QUARTER_TURN = 16'd9000;
	localparam logic [HAT_W-1:0] HALF_TURN = 16'd18000;
	localparam logic [HAT_W-1:0] THREE_QUARTER_TURN = 16'd27000;

	localparam logic signed [PHASE_W-1:0] CORDIC_GAIN_Q30 = 32'sh26DD3B6A;

	localparam logic signed [CFG_W-1:0] X_MIN_RESET = 17'sd0;
	localparam logic signed [CFG_W-1:0] X_MAX_RESET = 17'sd65535;
	localparam logic signed [CFG_W-1:0] Y_MIN_RESET = 17'sd0;
	localparam logic signed [CFG_W-1:0] Y_MAX_RESET = 17'sd65535;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_MIN = 2'd0,
		REG_X_MAX = 2'd1,
		REG_Y_MIN = 2'd2,
		REG_Y_MAX = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// sideband that travels beside every pipeline stage
	typedef struct packed {
		logic  vld;
		logic  mapped;
		quad_t quad;
	} side_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic [PHASE_W-1:0] atan_turn(input int unsigned i);
		logic [PHASE_W-1:0] v;
		unique case (i)
			0: v = 32'h20000000;
			1: v = 32'h12E4051D;
			2: v = 32'h09FB385B;
			3: v = 32'h051111D4;
			4: v = 32'h028B0D43;
			5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;
			7: v = 32'h00517C55;
			8: v = 32'h0028BE53;
			9: v = 32'h00145F2E;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2F9;
			15: v = 32'h0000517C;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A2F;
			19: v = 32'h00000517;
			20: v = 32'h0000028B;
			21: v = 32'h00000145;
			22: v = 32'h000000A2;
			23: v = 32'h00000051;
			24: v = 32'h00000028;
			25: v = 32'h00000014;
			26: v = 32'h0000000A;
			27: v = 32'h00000005;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### rtl/pov_phase.sv
// angle wrap, quadrant split and conversion of the remainder to binary phase
module pov_phase (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [pov_pkg::HAT_W-1:0]    hat_angle,
	output pov_pkg::side_t               out_side,
	output logic signed [pov_pkg::PHASE_W-1:0] phase
);
	import pov_pkg::*;

	// r * 2^32 / 36000 = r * 119304 + floor(r * 728 / 1125)
	localparam logic [16:0] PH_INT = 17'd119304;
	localparam logic [9:0] PH_FRAC = 10'd728;
	localparam logic [10:0] DIV_D = 11'd1125;
	// floor(2^34 / 1125), estimate is low by at most one
	localparam logic [23:0] DIV_M = 24'd15270994;
	localparam int DIV_SH = 34;

	logic [HAT_W-1:0] wrapped;
	logic [HAT_W-1:0] rem_full;
	quad_t            quad_c;

	side_t            side_s1, side_s2, side_s3, side_s4;
	logic [REM_W-1:0] r_s1;
	logic [30:0]      base_s2, base_s3;
	logic [22:0]      num_s2, num_s3;
	logic [12:0]      q0_s3;
	logic [46:0]      prod_c;
	logic [23:0]      back_c;
	logic [12:0]      q_c;
	logic signed [PHASE_W-1:0] phase_s4;

	always_comb begin
		wrapped = (hat_angle >= FULL_TURN) ? hat_angle - FULL_TURN : hat_angle;
		priority if (wrapped >= THREE_QUARTER_TURN) begin
			quad_c = QUAD_3;
			rem_full = wrapped - THREE_QUARTER_TURN;
		end else if (wrapped >= HALF_TURN) begin
			quad_c = QUAD_2;
			rem_full = wrapped - HALF_TURN;
		end else if (wrapped >= QUARTER_TURN) begin
			quad_c = QUAD_1;
			rem_full = wrapped - QUARTER_TURN;
		end else begin
			quad_c = QUAD_0;
			rem_full = wrapped;
		end
	end

	assign prod_c = {24'd0, num_s2} * {23'd0, DIV_M};
	assign back_c = {11'd0, q0_s3} * {13'd0, DIV_D};
	assign q_c = ({1'b0, num_s3} - back_c >= {13'd0, DIV_D}) ? q0_s3 + 13'd1 : q0_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
		end else if (en) begin
			side_s1 <= '{vld: in_vld, mapped: (hat_angle != HAT_CENTERED), quad: quad_c};
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= rem_full[REM_W-1:0];

			base_s2 <= 31'({17'd0, r_s1} * {14'd0, PH_INT});
			num_s2 <= 23'({13'd0, r_s1} * {14'd0, PH_FRAC});

			base_s3 <= base_s2;
			num_s3 <= num_s2;
			q0_s3 <= prod_c[DIV_SH+12:DIV_SH];

			phase_s4 <= signed'({1'b0, base_s3} + {19'd0, q_c});
		end
	end

	assign out_side = side_s4;
	assign phase = phase_s4;

endmodule

### rtl/pov_cordic.sv
// rotation cordic, one micro-rotation per pipeline stage, q30 sine and cosine
module pov_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  pov_pkg::side_t                     in_side,
	input  logic signed [pov_pkg::PHASE_W-1:0] phase,
	output pov_pkg::side_t                     out_side,
	output logic signed [pov_pkg::PHASE_W-1:0] cos_q30,
	output logic signed [pov_pkg::PHASE_W-1:0] sin_q30
);
	import pov_pkg::*;

	logic signed [PHASE_W-1:0] cx_s [1:CORDIC_STEPS];
	logic signed [PHASE_W-1:0] cy_s [1:CORDIC_STEPS];
	logic signed [PHASE_W-1:0] cz_s [1:CORDIC_STEPS];
	side_t                     side_s [1:CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [PHASE_W-1:0] ATAN = signed'(atan_turn(i));
		logic signed [PHASE_W-1:0] x_in, y_in, z_in;
		logic signed [PHASE_W-1:0] dx, dy;
		side_t side_in;

		if (i == 0) begin : g_seed
			assign x_in = CORDIC_GAIN_Q30;
			assign y_in = '0;
			assign z_in = phase;
			assign side_in = in_side;
		end else begin : g_chain
			assign x_in = cx_s[i];
			assign y_in = cy_s[i];
			assign z_in = cz_s[i];
			assign side_in = side_s[i];
		end

		assign dx = y_in >>> i;
		assign dy = x_in >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[i+1] <= '0;
			end else if (en) begin
				side_s[i+1] <= side_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				// rotate toward zero residual angle
				if (!z_in[PHASE_W-1]) begin
					cx_s[i+1] <= x_in - dx;
					cy_s[i+1] <= y_in + dy;
					cz_s[i+1] <= z_in - ATAN;
				end else begin
					cx_s[i+1] <= x_in + dx;
					cy_s[i+1] <= y_in - dy;
					cz_s[i+1] <= z_in + ATAN;
				end
			end
		end
	end

	assign out_side = side_s[CORDIC_STEPS];
	assign cos_q30 = cx_s[CORDIC_STEPS];
	assign sin_q30 = cy_s[CORDIC_STEPS];

endmodule

### rtl/pov_map.sv
// rounding of sine and cosine, quadrant fold and scaling onto the axis ranges
module pov_map #(
	parameter int AXIS_WIDTH = 18,
	parameter int TRIG_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  pov_pkg::side_t                     in_side,
	input  logic signed [pov_pkg::PHASE_W-1:0] cos_q30,
	input  logic signed [pov_pkg::PHASE_W-1:0] sin_q30,
	input  logic signed [pov_pkg::CFG_W-1:0]   x_minimum,
	input  logic signed [pov_pkg::CFG_W-1:0]   y_minimum,
	input  logic signed [AXIS_WIDTH-1:0]       x_half,
	input  logic signed [AXIS_WIDTH-1:0]       y_half,
	output logic                               out_vld,
	output logic                               mapped,
	output logic signed [pov_pkg::CFG_W-1:0]   x_axis,
	output logic signed [pov_pkg::CFG_W-1:0]   y_axis
);
	import pov_pkg::*;

	localparam int SH = 30 - TRIG_FRAC_BITS;
	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int WW = TRIG_FRAC_BITS + 3;
	localparam int PW = WW + AXIS_WIDTH;
	localparam int LW = CFG_W + TRIG_FRAC_BITS;
	localparam int NW = ((PW > LW) ? PW : LW) + 1;

	localparam logic signed [PHASE_W:0] RND = (PHASE_W+1)'(1) <<< (SH - 1);
	localparam logic signed [PHASE_W:0] ONE_WIDE = (PHASE_W+1)'(1) <<< TRIG_FRAC_BITS;
	localparam logic signed [WW-1:0] ONE_W = WW'(1) <<< TRIG_FRAC_BITS;
	localparam logic signed [NW-1:0] FRAC_MASK = (NW'(1) <<< TRIG_FRAC_BITS) - NW'(1);

	side_t side_s1, side_s2, side_s3, side_s4;
	logic signed [TW-1:0] s_s1, c_s1;
	logic signed [WW-1:0] wx_s2, wy_s2;
	logic signed [PW-1:0] px_s3, py_s3;
	logic signed [CFG_W-1:0] x_s4, y_s4;

	logic signed [PHASE_W:0] s_rnd, c_rnd, s_clp, c_clp;
	logic signed [TW-1:0] s_q, c_q;
	logic signed [NW-1:0] nx, ny, tx, ty;

	function automatic logic signed [PHASE_W:0] clamp_one(input logic signed [PHASE_W:0] v);
		logic signed [PHASE_W:0] r;
		if (v > ONE_WIDE) r = ONE_WIDE;
		else if (v < -ONE_WIDE) r = -ONE_WIDE;
		else r = v;
		return r;
	endfunction

	always_comb begin
		s_rnd = (signed'({sin_q30[PHASE_W-1], sin_q30}) + RND) >>> SH;
		c_rnd = (signed'({cos_q30[PHASE_W-1], cos_q30}) + RND) >>> SH;
		s_clp = clamp_one(s_rnd);
		c_clp = clamp_one(c_rnd);
	end

	// fold the first-quadrant pair into the hat's quadrant
	always_comb begin
		unique case (side_s1.quad)
			QUAD_1: begin
				s_q = c_s1;
				c_q = -s_s1;
			end
			QUAD_2: begin
				s_q = -s_s1;
				c_q = -c_s1;
			end
			QUAD_3: begin
				s_q = -c_s1;
				c_q = s_s1;
			end
			default: begin
				s_q = s_s1;
				c_q = c_s1;
			end
		endcase
	end

	always_comb begin
		nx = (NW'(x_minimum) <<< TRIG_FRAC_BITS) + NW'(px_s3);
		ny = (NW'(y_minimum) <<< TRIG_FRAC_BITS) + NW'(py_s3);
		// drop the fraction toward zero
		tx = (nx[NW-1] ? nx + FRAC_MASK : nx) >>> TRIG_FRAC_BITS;
		ty = (ny[NW-1] ? ny + FRAC_MASK : ny) >>> TRIG_FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
		end else if (en) begin
			side_s1 <= in_side;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1 <= s_clp[TW-1:0];
			c_s1 <= c_clp[TW-1:0];

			wx_s2 <= WW'(s_q) + ONE_W;
			wy_s2 <= ONE_W - WW'(c_q);

			px_s3 <= PW'(wx_s2) * PW'(x_half);
			py_s3 <= PW'(wy_s2) * PW'(y_half);

			x_s4 <= side_s3.mapped ? tx[CFG_W-1:0] : '0;
			y_s4 <= side_s3.mapped ? ty[CFG_W-1:0] : '0;
		end
	end

	assign out_vld = side_s4.vld;
	assign mapped = side_s4.mapped;
	assign x_axis = x_s4;
	assign y_axis = y_s4;

endmodule

### rtl/pov_hat_to_axis_mapper_core.sv
// top level of the joystick hat to x/y axis mapper
//
//  port group   dir  payload
//  s_axis       in   tdata[15:0] hat_angle
//  m_axis       out  tdata[16:0] x_axis, [33:17] y_axis, rest zero; tuser[0] mapped
//  cfg          in   cfg_we, cfg_index (register number), cfg_data[16:0]
//
// one beat enters per cycle unless m_axis stalls; its result is offered once the beat has passed
// all 36 register stages (4 phase, 28 cordic, 4 mapping; halves computed ahead)
// the whole pipeline advances whenever the output register is empty or taken,
// so a stall on m_axis freezes every stage and nothing is dropped or repeated
// reset clears all valid bits and loads the default axis ranges
module pov_hat_to_axis_mapper_core #(
	parameter int AXIS_WIDTH = 18,
	parameter int TRIG_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [15:0]                      s_axis_tdata,   // hat_angle
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [39:0]                      m_axis_tdata,   // x_axis, y_axis, zero pad
	output logic [0:0]                       m_axis_tuser,   // mapped
	input  logic                             cfg_we,
	input  logic [pov_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pov_pkg::CFG_W-1:0]        cfg_data
);
	import pov_pkg::*;

	localparam int DW = 2 * CFG_W;

	logic signed [CFG_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic signed [AXIS_WIDTH-1:0] x_half_q, y_half_q;
	logic signed [DW-1:0] x_diff_w, y_diff_w;
	logic signed [AXIS_WIDTH-1:0] x_diff, y_diff;

	logic en;
	side_t ph_side, co_side;
	logic signed [PHASE_W-1:0] phase;
	logic signed [PHASE_W-1:0] cos_q30, sin_q30;
	logic out_vld, mapped;
	logic signed [CFG_W-1:0] x_axis, y_axis;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= X_MIN_RESET;
			x_max_q <= X_MAX_RESET;
			y_min_q <= Y_MIN_RESET;
			y_max_q <= Y_MAX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_X_MIN: x_min_q <= cfg_data;
				REG_X_MAX: x_max_q <= cfg_data;
				REG_Y_MIN: y_min_q <= cfg_data;
				REG_Y_MAX: y_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// range difference wraps in AXIS_WIDTH bits, half rounds toward zero
	always_comb begin
		x_diff_w = DW'(x_max_q) - DW'(x_min_q);
		y_diff_w = DW'(y_max_q) - DW'(y_min_q);
		x_diff = x_diff_w[AXIS_WIDTH-1:0];
		y_diff = y_diff_w[AXIS_WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		x_half_q <= (x_diff + signed'(AXIS_WIDTH'(x_diff[AXIS_WIDTH-1]))) >>> 1;
		y_half_q <= (y_diff + signed'(AXIS_WIDTH'(y_diff[AXIS_WIDTH-1]))) >>> 1;
	end

	assign en = !out_vld || m_axis_tready;
	assign s_axis_tready = en;

	pov_phase u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (s_axis_tvalid),
		.hat_angle (s_axis_tdata),
		.out_side  (ph_side),
		.phase     (phase)
	);

	pov_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_side  (ph_side),
		.phase    (phase),
		.out_side (co_side),
		.cos_q30  (cos_q30),
		.sin_q30  (sin_q30)
	);

	pov_map #(
		.AXIS_WIDTH     (AXIS_WIDTH),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_side   (co_side),
		.cos_q30   (cos_q30),
		.sin_q30   (sin_q30),
		.x_minimum (x_min_q),
		.y_minimum (y_min_q),
		.x_half    (x_half_q),
		.y_half    (y_half_q),
		.out_vld   (out_vld),
		.mapped    (mapped),
		.x_axis    (x_axis),
		.y_axis    (y_axis)
	);

	assign m_axis_tvalid = out_vld;
	assign m_axis_tdata = {6'd0, y_axis, x_axis};
	assign m_axis_tuser = mapped;

endmodule
